/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/cpt_pkg.sv */
`timescale 1ns / 1ps
package cpt_pkg;

   // Most source bytes / codepage characters per string
   localparam int MAX_CHARS  = 16;
   localparam int CNT_W      = $clog2(MAX_CHARS + 1);
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 6;
   localparam int KIND_W     = 2;
   localparam int MAXLEN_W   = 5;
   localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int PART_W     = 10;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN   = 1'd1;
   localparam logic [MAXLEN_W-1:0]  MAX_LEN_RESET = 5'd16;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam int KANA_COUNT = 83;
   localparam int KANA_IDX_W = $clog2(KANA_COUNT);
   localparam int SYM_COUNT  = 14;
   localparam int SYM_IDX_W  = $clog2(SYM_COUNT);

   localparam logic [BYTE_W-1:0] CP_LETTER_FIRST = 8'h1A;
   localparam logic [BYTE_W-1:0] CP_LETTER_LAST  = 8'h33;
   localparam logic [BYTE_W-1:0] CP_DIGIT_FIRST  = 8'h10;
   localparam logic [BYTE_W-1:0] CP_DIGIT_LAST   = 8'h19;
   localparam logic [BYTE_W-1:0] CP_SPACE        = 8'h0F;
   localparam logic [BYTE_W-1:0] CP_SYM_FIRST    = 8'h34;
   localparam logic [BYTE_W-1:0] CP_SYM_LAST     = 8'h41;
   localparam logic [BYTE_W-1:0] CP_KANA_FIRST   = 8'h42;
   localparam logic [BYTE_W-1:0] CP_KANA_LAST    = 8'h94;
   localparam logic [BYTE_W-1:0] CP_CTRL         = 8'h00;

   localparam logic [BYTE_W-1:0] ASC_UPPER_A   = 8'h41;
   localparam logic [BYTE_W-1:0] ASC_UPPER_Z   = 8'h5A;
   localparam logic [BYTE_W-1:0] ASC_LOWER_A   = 8'h61;
   localparam logic [BYTE_W-1:0] ASC_LOWER_Z   = 8'h7A;
   localparam logic [BYTE_W-1:0] ASC_DIGIT_0   = 8'h30;
   localparam logic [BYTE_W-1:0] ASC_DIGIT_9   = 8'h39;
   localparam logic [BYTE_W-1:0] ASC_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] ASC_CTRL      = 8'h01;
   localparam logic [BYTE_W-1:0] ASC_NUL       = 8'h00;
   localparam logic [BYTE_W-1:0] CJK_HIGH      = 8'h30;
   localparam logic [BYTE_W-1:0] UTF8_CJK_LEAD = 8'hE3;
   localparam logic [1:0]        UTF8_CONT_TAG = 2'b10;
   localparam logic [3:0]        UTF8_3B_TAG   = 4'hE;

   localparam logic [BYTE_W-1:0] KANA_ROM [KANA_COUNT] = '{
      8'd2,   8'd155, 8'd156, 8'd161, 8'd163, 8'd165, 8'd167, 8'd169, 8'd195, 8'd227,
      8'd229, 8'd231, 8'd242, 8'd243, 8'd162, 8'd164, 8'd166, 8'd168, 8'd170, 8'd171,
      8'd173, 8'd175, 8'd177, 8'd179, 8'd181, 8'd183, 8'd185, 8'd187, 8'd189, 8'd191,
      8'd193, 8'd196, 8'd198, 8'd200, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207,
      8'd210, 8'd213, 8'd216, 8'd219, 8'd222, 8'd223, 8'd224, 8'd225, 8'd226, 8'd228,
      8'd230, 8'd232, 8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd239, 8'd172, 8'd174,
      8'd176, 8'd178, 8'd180, 8'd182, 8'd184, 8'd186, 8'd188, 8'd190, 8'd192, 8'd194,
      8'd197, 8'd199, 8'd201, 8'd208, 8'd211, 8'd214, 8'd217, 8'd220, 8'd209, 8'd212,
      8'd215, 8'd218, 8'd221
   };

   // ASCII symbols for codepage codes 0x34..0x41
   localparam logic [BYTE_W-1:0] SYM_ROM [SYM_COUNT] = '{
      8'h21, 8'h22, 8'h23, 8'h60, 8'h2A, 8'h2B, 8'h2C,
      8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3D, 8'h3F, 8'h40
   };

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      TERM_NONE  = 2'd0,
      TERM_DONE  = 2'd1,
      TERM_ERROR = 2'd2
   } term_type;

   // One queued command: zeros to expand, up to three bytes, terminal
   typedef struct packed {
      logic [CNT_W-1:0]            zeros;
      logic [1:0]                  nbytes;
      logic [2:0][BYTE_W-1:0]      bytes;
      term_type                    term;
      logic [LEN_W-1:0]            length;
   } cmd_type;

   typedef struct packed {
      logic              hit;
      logic [BYTE_W-1:0] code;
   } map_type;

   typedef struct packed {
      logic                   hit;
      logic [KANA_IDX_W-1:0]  idx;
   } kana_hit_type;

   typedef struct packed {
      logic [1:0]             nbytes;
      logic [2:0][BYTE_W-1:0] bytes;
   } utf8_type;

   // UTF-8 single byte to codepage
   function automatic map_type ascii_to_cp(input logic [BYTE_W-1:0] b);
      map_type r;
      r = '{hit: 1'b0, code: '0};
      if (b >= ASC_UPPER_A && b <= ASC_UPPER_Z) begin
         r = '{hit: 1'b1, code: CP_LETTER_FIRST + (b - ASC_UPPER_A)};
      end else if (b >= ASC_LOWER_A && b <= ASC_LOWER_Z) begin
         r = '{hit: 1'b1, code: CP_LETTER_FIRST + (b - ASC_LOWER_A)};
      end else if (b >= ASC_DIGIT_0 && b <= ASC_DIGIT_9) begin
         r = '{hit: 1'b1, code: CP_DIGIT_FIRST + (b - ASC_DIGIT_0)};
      end else if (b == ASC_SPACE) begin
         r = '{hit: 1'b1, code: CP_SPACE};
      end else if (b == ASC_CTRL) begin
         r = '{hit: 1'b1, code: CP_CTRL};
      end else begin
         for (int i = 0; i < SYM_COUNT; i++) begin
            if (SYM_ROM[i] == b) begin
               r = '{hit: 1'b1, code: CP_SYM_FIRST + BYTE_W'(i)};
            end
         end
      end
      return r;
   endfunction

   // Inverse katakana lookup on the low byte of a U+30xx codepoint
   function automatic kana_hit_type kana_index(input logic [BYTE_W-1:0] off);
      kana_hit_type r;
      r = '{hit: 1'b0, idx: '0};
      for (int i = 0; i < KANA_COUNT; i++) begin
         if (KANA_ROM[i] == off) begin
            r = '{hit: 1'b1, idx: KANA_IDX_W'(i)};
         end
      end
      return r;
   endfunction

   // Codepage byte (non-zero) to one or three UTF-8 bytes
   function automatic utf8_type cp_to_utf8(input logic [BYTE_W-1:0] b);
      utf8_type          r;
      logic [BYTE_W-1:0] sym_off;
      logic [BYTE_W-1:0] kana_off;
      logic [BYTE_W-1:0] rom;
      sym_off  = b - CP_SYM_FIRST;
      kana_off = b - CP_KANA_FIRST;
      rom      = KANA_ROM[kana_off[KANA_IDX_W-1:0]];
      r.nbytes = 2'd1;
      r.bytes  = '0;
      if (b >= CP_LETTER_FIRST && b <= CP_LETTER_LAST) begin
         r.bytes[0] = ASC_UPPER_A + (b - CP_LETTER_FIRST);
      end else if (b >= CP_DIGIT_FIRST && b <= CP_DIGIT_LAST) begin
         r.bytes[0] = ASC_DIGIT_0 + (b - CP_DIGIT_FIRST);
      end else if (b == CP_SPACE) begin
         r.bytes[0] = ASC_SPACE;
      end else if (b >= CP_SYM_FIRST && b <= CP_SYM_LAST) begin
         r.bytes[0] = SYM_ROM[sym_off[SYM_IDX_W-1:0]];
      end else if (b >= CP_KANA_FIRST && b <= CP_KANA_LAST) begin
         r.nbytes   = 2'd3;
         r.bytes[0] = UTF8_CJK_LEAD;
         r.bytes[1] = {UTF8_CONT_TAG, 4'd0, rom[7:6]};
         r.bytes[2] = {UTF8_CONT_TAG, rom[5:0]};
      end else begin
         r.bytes[0] = ASC_SPACE;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/cpt_ifs.sv */
`timescale 1ns / 1ps
interface cpt_req_if import cpt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface cpt_rsp_if import cpt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] out_byte;
   logic [LEN_W-1:0]  length;
   logic              last;

   modport source (output valid, output kind, output out_byte, output length, output last,
                   input ready);
   modport sink   (input valid, input kind, input out_byte, input length, input last,
                   output ready);
endinterface

/* hw/rtl/cpt_front.sv */
`timescale 1ns / 1ps
module cpt_front import cpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   cpt_req_if.sink               req_ch,
   input  logic                  q_full,
   output logic                  push,
   output cmd_type               push_cmd
);

   logic                direction_ff, direction_in;
   logic [MAXLEN_W-1:0] max_len_ff, max_len_in;
   logic [1:0]          phase_ff, phase_in;
   logic [PART_W-1:0]   part_ff, part_in;
   logic                error_ff, error_in;
   logic                nul_ff, nul_in;
   logic [LEN_W-1:0]    emitted_ff, emitted_in;
   logic [CNT_W-1:0]    zeros_ff, zeros_in;
   logic [CNT_W-1:0]    in_count_ff, in_count_in;

   logic                accept;
   logic [BYTE_W-1:0]   b;
   logic [CMP_W-1:0]    lim;
   logic                room;
   logic [15:0]         cp;
   map_type             asc;
   kana_hit_type        kana;
   utf8_type            utf;
   cmd_type             cmd;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.in_byte;

   assign lim  = (CMP_W'(max_len_ff) > CMP_W'(MAX_CHARS)) ? CMP_W'(MAX_CHARS)
                                                         : CMP_W'(max_len_ff);
   assign room = CMP_W'(emitted_ff) < lim;
   assign cp   = {part_ff, b[5:0]};
   assign asc  = ascii_to_cp(b);
   assign kana = kana_index(cp[7:0]);
   assign utf  = cp_to_utf8(b);

   always_comb begin
      direction_in = direction_ff;
      max_len_in   = max_len_ff;
      phase_in     = phase_ff;
      part_in      = part_ff;
      error_in     = error_ff;
      nul_in       = nul_ff;
      emitted_in   = emitted_ff;
      zeros_in     = zeros_ff;
      in_count_in  = in_count_ff;
      cmd          = '{zeros: '0, nbytes: 2'd0, bytes: '0, term: TERM_NONE, length: '0};

      if (accept) begin
         if (!direction_ff) begin
            if (!error_ff && !nul_ff) begin
               if (phase_ff == 2'd0) begin
                  if (!room) begin
                     // output limit reached: byte dropped
                  end else if (b == ASC_NUL) begin
                     nul_in = 1'b1;
                  end else if (asc.hit) begin
                     cmd.nbytes   = 2'd1;
                     cmd.bytes[0] = asc.code;
                     emitted_in   = emitted_ff + 1'b1;
                  end else if (b[7:4] == UTF8_3B_TAG) begin
                     part_in  = {6'd0, b[3:0]};
                     phase_in = 2'd1;
                  end else begin
                     error_in = 1'b1;
                  end
               end else if (b[7:6] != UTF8_CONT_TAG) begin
                  error_in = 1'b1;
                  phase_in = 2'd0;
               end else if (phase_ff == 2'd1) begin
                  part_in  = {part_ff[3:0], b[5:0]};
                  phase_in = 2'd2;
               end else begin
                  phase_in = 2'd0;
                  part_in  = '0;
                  if (cp[15:8] == CJK_HIGH && kana.hit) begin
                     if (room) begin
                        cmd.nbytes   = 2'd1;
                        cmd.bytes[0] = CP_KANA_FIRST + BYTE_W'(kana.idx);
                        emitted_in   = emitted_ff + 1'b1;
                     end
                  end else begin
                     error_in = 1'b1;
                  end
               end
            end
         end else if (in_count_ff < CNT_W'(MAX_CHARS)) begin
            in_count_in = in_count_ff + 1'b1;
            if (b == ASC_NUL) begin
               zeros_in = zeros_ff + 1'b1;
            end else begin
               // held zeros flush ahead of the converted character
               cmd.zeros  = zeros_ff;
               cmd.nbytes = utf.nbytes;
               cmd.bytes  = utf.bytes;
               emitted_in = emitted_ff + LEN_W'(zeros_ff) + LEN_W'(utf.nbytes);
               zeros_in   = '0;
            end
         end

         if (req_ch.end_of_string) begin
            cmd.term    = (!direction_ff && (error_in || phase_in != 2'd0)) ? TERM_ERROR
                                                                            : TERM_DONE;
            cmd.length  = emitted_in;
            phase_in    = 2'd0;
            part_in     = '0;
            error_in    = 1'b0;
            nul_in      = 1'b0;
            emitted_in  = '0;
            zeros_in    = '0;
            in_count_in = '0;
         end
      end

      if (csr_we) begin
         if (csr_index == CSR_DIRECTION) begin
            direction_in = csr_wdata[0];
            phase_in     = 2'd0;
            part_in      = '0;
            error_in     = 1'b0;
            nul_in       = 1'b0;
            emitted_in   = '0;
            zeros_in     = '0;
            in_count_in  = '0;
         end else if (csr_index == CSR_MAX_LEN) begin
            max_len_in = csr_wdata[MAXLEN_W-1:0];
         end
      end
   end

   assign push     = accept && (cmd.zeros != '0 || cmd.nbytes != 2'd0 || cmd.term != TERM_NONE);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         max_len_ff   <= MAX_LEN_RESET;
         phase_ff     <= 2'd0;
         part_ff      <= '0;
         error_ff     <= 1'b0;
         nul_ff       <= 1'b0;
         emitted_ff   <= '0;
         zeros_ff     <= '0;
         in_count_ff  <= '0;
      end else begin
         direction_ff <= direction_in;
         max_len_ff   <= max_len_in;
         phase_ff     <= phase_in;
         part_ff      <= part_in;
         error_ff     <= error_in;
         nul_ff       <= nul_in;
         emitted_ff   <= emitted_in;
         zeros_ff     <= zeros_in;
         in_count_ff  <= in_count_in;
      end
   end

endmodule

/* hw/rtl/cpt_fifo.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cpt_fifo import cpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    not_empty
);

   cmd_type              q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == Q_CNT_W'(Q_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= Q_CNT_W'(Q_DEPTH), "queue overfilled")
   `ASSERT_ALWAYS(a_no_push_full, clock, reset, !(push && full), "push into full queue")
   `ASSERT_ALWAYS(a_no_pop_empty, clock, reset, !(pop && !not_empty), "pop from empty queue")

endmodule

/* hw/rtl/cpt_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cpt_back import cpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head,
   input  logic    not_empty,
   output logic    pop,
   cpt_rsp_if.source rsp_ch
);

   logic [CNT_W-1:0]  zero_cnt_ff, zero_cnt_in;
   logic [1:0]        byte_idx_ff, byte_idx_in;
   logic              out_valid_ff, out_valid_in;
   kind_type          out_kind_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [LEN_W-1:0]  out_len_ff;
   logic              out_last_ff;

   logic              produce;
   kind_type          res_kind;
   logic [BYTE_W-1:0] res_byte;
   logic [LEN_W-1:0]  res_len;
   logic              res_last;

   assign produce = not_empty && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      zero_cnt_in = zero_cnt_ff;
      byte_idx_in = byte_idx_ff;
      res_kind    = KIND_DATA;
      res_byte    = '0;
      res_len     = '0;
      res_last    = 1'b0;
      if (zero_cnt_ff < head.zeros) begin
         // embedded zero comes out as 0x01
         res_byte    = ASC_CTRL;
         res_last    = (CNT_W'(zero_cnt_ff + 1'b1) == head.zeros) && head.nbytes == 2'd0 &&
                       head.term == TERM_NONE;
         zero_cnt_in = zero_cnt_ff + 1'b1;
      end else if (byte_idx_ff < head.nbytes) begin
         res_byte    = head.bytes[byte_idx_ff];
         res_last    = (2'(byte_idx_ff + 1'b1) == head.nbytes) && head.term == TERM_NONE;
         byte_idx_in = byte_idx_ff + 1'b1;
      end else begin
         res_last = 1'b1;
         res_len  = head.length;
         unique case (head.term)
            TERM_ERROR: begin
               res_kind = KIND_ERROR;
               res_len  = '0;
            end
            TERM_DONE: res_kind = KIND_DONE;
            default:   res_kind = KIND_DONE;
         endcase
      end
      if (res_last) begin
         zero_cnt_in = '0;
         byte_idx_in = 2'd0;
      end
   end

   assign pop = produce && res_last;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (produce) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_cnt_ff  <= '0;
         byte_idx_ff  <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (produce) begin
            zero_cnt_ff <= zero_cnt_in;
            byte_idx_ff <= byte_idx_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         out_kind_ff <= res_kind;
         out_byte_ff <= res_byte;
         out_len_ff  <= res_len;
         out_last_ff <= res_last;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.kind     = out_kind_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.length   = out_len_ff;
   assign rsp_ch.last     = out_last_ff;

   `ASSERT_ALWAYS(a_zero_bound, clock, reset, !not_empty || zero_cnt_ff <= head.zeros, "zero count past command")
   `ASSERT_ALWAYS(a_byte_bound, clock, reset, !not_empty || byte_idx_ff <= head.nbytes, "byte index past command")
   `ASSERT_NEXT(a_pop_last, clock, reset, pop, out_valid_ff && out_last_ff, "pop without last result")

endmodule

/* hw/rtl/codepage_utf8_transcoder.sv */
`timescale 1ns / 1ps
// Channel   Direction  Payload                              Transfer when
// req_ch    in         in_byte[7:0], end_of_string          valid && ready
// rsp_ch    out        kind[1:0], out_byte[7:0], length[5:0], last   valid && ready
// csr_*     in         csr_index[0], csr_wdata[4:0]         csr_we
//
// Front takes one byte per cycle while the 4-entry command queue has room.
// Back delivers one result per cycle from its output register while rsp_ch is ready
// and the queue holds a command; a byte causes 0 to 19 results (held zeros, up to 3
// bytes, terminal), which pass through the queue and then the output register.
// A stalled rsp_ch fills the queue, then drops req_ch.ready; the output register
// keeps taking a new result in the cycle the old one transfers.
// Reset is synchronous: direction 0, max_len 16, queue empty, per-string state clear.
module codepage_utf8_transcoder import cpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   cpt_req_if.sink               req_ch,
   cpt_rsp_if.source             rsp_ch
);

   // front to queue
   logic    push;
   cmd_type push_cmd;
   logic    q_full;

   // queue to back
   logic    pop;
   cmd_type head;
   logic    not_empty;

   // Front: register file, UTF-8 sequence tracking, classification of each
   // byte into a command (zeros to flush, bytes, terminal result).
   cpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // Decouples the byte-per-cycle front from the result-per-cycle back; either side can stall.
   cpt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty)
   );

   // Back: expands each command into result transfers.
   cpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* dv/codepage_utf8_transcoder_checker.sv */
`timescale 1ns / 1ps
module codepage_utf8_transcoder_checker import cpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   cpt_req_if                    req_mon,
   cpt_rsp_if                    rsp_mon,
   output int                    fail_count,
   output int                    results_owed
);

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic              last;
   } result_t;

   // low byte of U+30xx for codepage codes 0x42 upwards
   localparam logic [7:0] KATAKANA_LOW [KANA_COUNT] = '{
      8'd2,   8'd155, 8'd156, 8'd161, 8'd163, 8'd165, 8'd167, 8'd169, 8'd195, 8'd227,
      8'd229, 8'd231, 8'd242, 8'd243, 8'd162, 8'd164, 8'd166, 8'd168, 8'd170, 8'd171,
      8'd173, 8'd175, 8'd177, 8'd179, 8'd181, 8'd183, 8'd185, 8'd187, 8'd189, 8'd191,
      8'd193, 8'd196, 8'd198, 8'd200, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207,
      8'd210, 8'd213, 8'd216, 8'd219, 8'd222, 8'd223, 8'd224, 8'd225, 8'd226, 8'd228,
      8'd230, 8'd232, 8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd239, 8'd172, 8'd174,
      8'd176, 8'd178, 8'd180, 8'd182, 8'd184, 8'd186, 8'd188, 8'd190, 8'd192, 8'd194,
      8'd197, 8'd199, 8'd201, 8'd208, 8'd211, 8'd214, 8'd217, 8'd220, 8'd209, 8'd212,
      8'd215, 8'd218, 8'd221
   };

   // ASCII for codepage codes 0x34..0x41
   localparam logic [7:0] SYMBOL_ASCII [SYM_COUNT] = '{
      8'h21, 8'h22, 8'h23, 8'h60, 8'h2A, 8'h2B, 8'h2C,
      8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3D, 8'h3F, 8'h40
   };

   logic              to_utf8_mode;
   logic [4:0]        len_limit;
   logic [1:0]        seq_step;
   logic [9:0]        cp_bits;
   logic              bad_seen;
   logic              nul_hit;
   int                out_count;
   int                zero_run;
   int                taken;
   result_t           step_out [$];
   result_t           owed [$];

   task automatic clear_string();
      seq_step  = 2'd0;
      cp_bits   = '0;
      bad_seen  = 1'b0;
      nul_hit   = 1'b0;
      out_count = 0;
      zero_run  = 0;
      taken     = 0;
   endtask

   task automatic push_data(input logic [7:0] b);
      step_out.push_back('{KIND_DATA, b, '0, 1'b0});
      out_count++;
   endtask

   // UTF-8 in, codepage out
   task automatic fold_utf8(input logic [7:0] b);
      int          lim;
      logic        hit;
      logic [15:0] cp;
      lim = (len_limit > MAX_CHARS) ? MAX_CHARS : int'(len_limit);
      hit = 1'b0;
      if (bad_seen || nul_hit) return;
      if (seq_step == 2'd0) begin
         if (out_count >= lim) return;
         if (b == 8'h00) begin
            nul_hit = 1'b1;
         end else if (b >= 8'h41 && b <= 8'h5A) begin
            push_data(8'h1A + (b - 8'h41));
         end else if (b >= 8'h61 && b <= 8'h7A) begin
            push_data(8'h1A + (b - 8'h61));
         end else if (b >= 8'h30 && b <= 8'h39) begin
            push_data(8'h10 + (b - 8'h30));
         end else if (b == 8'h20) begin
            push_data(8'h0F);
         end else if (b == 8'h01) begin
            push_data(8'h00);
         end else begin
            for (int i = 0; i < SYM_COUNT; i++) begin
               if (!hit && SYMBOL_ASCII[i] == b) begin
                  push_data(8'h34 + 8'(i));
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               if (b[7:4] == 4'hE) begin
                  cp_bits  = {6'd0, b[3:0]};
                  seq_step = 2'd1;
               end else begin
                  bad_seen = 1'b1;
               end
            end
         end
         return;
      end
      if (b[7:6] != 2'b10) begin
         bad_seen = 1'b1;
         seq_step = 2'd0;
         return;
      end
      if (seq_step == 2'd1) begin
         cp_bits  = {cp_bits[3:0], b[5:0]};
         seq_step = 2'd2;
         return;
      end
      cp       = {cp_bits, b[5:0]};
      seq_step = 2'd0;
      cp_bits  = '0;
      if (cp[15:8] == 8'h30) begin
         for (int i = 0; i < KANA_COUNT; i++) begin
            if (!hit && KATAKANA_LOW[i] == cp[7:0]) begin
               hit = 1'b1;
               // limit may have been lowered while the sequence was open
               if (out_count < lim) push_data(8'h42 + 8'(i));
            end
         end
      end
      if (!hit) bad_seen = 1'b1;
   endtask

   // codepage in, UTF-8 out; zeros held until something follows them
   task automatic expand_codepage(input logic [7:0] b);
      logic [7:0] low;
      if (taken >= MAX_CHARS) return;
      taken++;
      if (b == 8'h00) begin
         zero_run++;
         return;
      end
      repeat (zero_run) push_data(8'h01);
      zero_run = 0;
      if (b >= 8'h1A && b <= 8'h33) begin
         push_data(8'h41 + (b - 8'h1A));
      end else if (b >= 8'h10 && b <= 8'h19) begin
         push_data(8'h30 + (b - 8'h10));
      end else if (b == 8'h0F) begin
         push_data(8'h20);
      end else if (b >= 8'h34 && b <= 8'h41) begin
         push_data(SYMBOL_ASCII[b - 8'h34]);
      end else if (b >= 8'h42 && b <= 8'h94) begin
         low = KATAKANA_LOW[b - 8'h42];
         push_data(8'hE3);
         push_data({6'b100000, low[7:6]});
         push_data({2'b10, low[5:0]});
      end else begin
         push_data(8'h20);
      end
   endtask

   task automatic transcode_byte(input logic [7:0] b, input logic eos);
      step_out.delete();
      if (to_utf8_mode) expand_codepage(b);
      else fold_utf8(b);
      if (eos) begin
         if (!to_utf8_mode && (bad_seen || seq_step != 2'd0))
            step_out.push_back('{KIND_ERROR, 8'h00, '0, 1'b0});
         else
            step_out.push_back('{KIND_DONE, 8'h00, LEN_W'(out_count), 1'b0});
         clear_string();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) owed.push_back(step_out[i]);
   endtask

   always @(posedge clock) begin
      result_t got;
      result_t want;
      if (reset) begin
         to_utf8_mode = 1'b0;
         len_limit    = MAX_LEN_RESET;
         clear_string();
         owed.delete();
         fail_count   = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_DIRECTION) begin
               to_utf8_mode = csr_wdata[0];
               clear_string();
            end else if (csr_index == CSR_MAX_LEN) begin
               len_limit = csr_wdata[4:0];
            end
         end
         if (req_mon.valid && req_mon.ready)
            transcode_byte(req_mon.in_byte, req_mon.end_of_string);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{kind_type'(rsp_mon.kind), rsp_mon.out_byte, rsp_mon.length, rsp_mon.last};
            if (owed.size() == 0) begin
               fail_count++;
               $display("%0t: expected no result, got kind %0d byte %02h length %0d last %0b",
                        $time, got.kind, got.data, got.len, got.last);
            end else begin
               want = owed.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display({"%0t: expected kind %0d byte %02h length %0d last %0b,",
                            " got kind %0d byte %02h length %0d last %0b"},
                           $time, want.kind, want.data, want.len, want.last,
                           got.kind, got.data, got.len, got.last);
               end
            end
         end
      end
      results_owed = owed.size();
   end

endmodule

/* dv/codepage_utf8_transcoder_tb.sv */
`timescale 1ns / 1ps
module codepage_utf8_transcoder_tb;
   import cpt_pkg::*;

   localparam int LONG_HOLD = 300;   // cycles the result side refuses during the fill test
   localparam int SETTLE    = 30;    // quiet cycles after the last result before a csr write
   localparam int PHASES    = 9;
   localparam int PER_PHASE = 4;     // random source bytes per phase

   // per-phase settings; the limits cover off, one byte, saturation and the nominal max
   localparam logic [4:0] PHASE_LIMIT [PHASES] = '{
      5'd0, 5'd1, 5'd31, 5'd16, 5'd2, 5'd17, 5'd3, 5'd8, 5'd16
   };
   localparam bit PHASE_DIR [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    fail_count;
   int                    results_owed;
   int                    items_left;
   bit                    gaps_on_req = 1'b1;
   bit                    gaps_on_rsp = 1'b1;
   bit                    long_hold   = 1'b0;
   bit                    cur_dir     = 1'b0;
   logic [BYTE_W-1:0]     src_bytes [$];

   cpt_req_if req_ch ();
   cpt_rsp_if rsp_ch ();

   codepage_utf8_transcoder dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // watches both channels and the csr port, predicts and compares
   codepage_utf8_transcoder_checker result_check (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One source byte: optional idle gap, then hold valid until the transfer.
   // valid is left high afterwards so back-to-back bytes need no extra edge.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
      int gap;
      gap = gaps_on_req ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.in_byte       <= b;
      req_ch.end_of_string <= eos;
      do @(posedge clock); while (!req_ch.ready);
      items_left--;
   endtask

   // Stop offering, wait for every owed result, then let the queue run dry.
   // Bytes that cause no result may still be in flight, hence the extra cycles.
   task automatic drain_and_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (results_owed == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Random string for the current direction. UTF-8 strings are mostly well
   // formed (letters, digits, symbols, katakana) with NULs, broken sequences
   // and raw noise mixed in; codepage strings are heavy on zeros so that held
   // zero runs, embedded zeros and over-long input all turn up.
   task automatic compose_string();
      int n;
      int pick;
      src_bytes.delete();
      if (cur_dir) begin
         n = $urandom_range(1, 20);
         repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      src_bytes.push_back(8'h00);
            else if (pick < 85) src_bytes.push_back(8'($urandom_range(1, 8'h94)));
            else                src_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         n = $urandom_range(1, 10);
         repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               src_bytes.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) +
                                   8'($urandom_range(0, 25)));
            end else if (pick < 55) begin
               src_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
            end else if (pick < 62) begin
               src_bytes.push_back($urandom_range(0, 1) ? 8'h20 : 8'h01);
            end else if (pick < 70) begin
               // punctuation block: mostly mapped, some not
               src_bytes.push_back(8'($urandom_range(8'h21, 8'h40)));
            end else if (pick < 86) begin
               // katakana area; now and then a lead outside U+30xx
               src_bytes.push_back(($urandom_range(0, 9) == 0) ?
                                   8'hE0 | 8'($urandom_range(0, 15)) : 8'hE3);
               src_bytes.push_back(8'h80 | 8'($urandom_range(0, 3)));
               src_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end else if (pick < 89) begin
               src_bytes.push_back(8'h00);
            end else if (pick < 94) begin
               // lead then a non-continuation, or lead alone (truncated if last)
               src_bytes.push_back(8'hE3);
               if ($urandom_range(0, 1)) src_bytes.push_back(8'($urandom_range(0, 127)));
            end else begin
               src_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // Sends the composed string; the phase quota may cut it short, leaving the
   // string open across the next csr write.
   task automatic send_text();
      foreach (src_bytes[i]) begin
         if (items_left > 0) send_byte(src_bytes[i], i == src_bytes.size() - 1);
      end
   endtask

   // Result side: random stalls per result, or one long refusal when asked.
   initial begin : rsp_drain
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            stall = gaps_on_rsp ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : stimulus
      req_ch.valid         <= 1'b0;
      req_ch.in_byte       <= '0;
      req_ch.end_of_string <= 1'b0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_DIRECTION;
      csr_wdata            <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // UTF-8 to codepage at reset settings.
      // Upper and lower case, digit ends, space, the 0x01 control, a symbol, a katakana
      send_byte(8'h5A, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h30, 1'b0);
      send_byte(8'h39, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'hE3, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(8'hB3, 1'b1);
      // bad lead
      send_byte(8'hFF, 1'b1);
      // string ends inside a sequence
      send_byte(8'hE3, 1'b0);
      send_byte(8'h81, 1'b1);
      // NUL stops the string, later bytes ignored
      send_byte(8'h42, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h43, 1'b1);
      // NUL inside a sequence is a bad continuation
      send_byte(8'hE3, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h41, 1'b1);
      // well-formed U+3000 has no codepage entry
      send_byte(8'hE3, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b1);

      // Codepage to UTF-8: embedded zero kept as 0x01, trailing zeros dropped,
      // unprintable code becomes a space
      drain_and_idle();
      cur_dir = 1'b1;
      write_reg(CSR_DIRECTION, 5'd1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h1A, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);

      // Random phases. Direction is rewritten in the early phases and at random
      // later, so some open strings carry over a max_len change only.
      for (int p = 0; p < PHASES; p++) begin
         drain_and_idle();
         if (p < 4 || $urandom_range(0, 1) == 1) begin
            cur_dir = PHASE_DIR[p];
            write_reg(CSR_DIRECTION, {4'($urandom_range(0, 15)), cur_dir});
         end
         write_reg(CSR_MAX_LEN, PHASE_LIMIT[p]);
         gaps_on_req = (p != 1) && ($urandom_range(0, 3) != 0);
         gaps_on_rsp = (p != 1) && ($urandom_range(0, 3) != 0);
         items_left  = PER_PHASE;
         while (items_left > 0) begin
            compose_string();
            send_text();
         end
      end

      // Fill test: result side refuses for a long stretch while the source keeps
      // offering back to back. Fifteen held zeros plus a katakana is the largest
      // burst a single byte can cause.
      drain_and_idle();
      cur_dir = 1'b1;
      write_reg(CSR_DIRECTION, 5'd1);
      gaps_on_req = 1'b0;
      gaps_on_rsp = 1'b1;
      long_hold   = 1'b1;
      for (int s = 0; s < 2; s++) begin
         repeat (15) send_byte(8'h00, 1'b0);
         send_byte((s == 0) ? CP_KANA_FIRST : CP_KANA_LAST, 1'b1);
      end
      repeat (4) begin
         send_byte(8'h1A, 1'b0);
         send_byte(8'h33, 1'b1);
      end

      // Source pauses mid-string until every owed result has come back
      gaps_on_req = 1'b1;
      send_byte(8'h10, 1'b0);
      send_byte(8'h00, 1'b0);
      drain_and_idle();
      send_byte(8'h00, 1'b0);
      send_byte(8'h19, 1'b1);

      drain_and_idle();
      if (fail_count == 0) begin
         $display("codepage_utf8_transcoder: match");
      end else begin
         $display("codepage_utf8_transcoder: mismatch");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run
   initial begin : watchdog
      #3_000_000;
      $display("codepage_utf8_transcoder: mismatch");
      $finish;
   end

endmodule
